### src/tqla_pkg.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent package
// Shared sizes, fixed-point formats, command and register codes, and the
// control word of the shared multiplier.
// ----------------------------------------------------------------------------
package tqla_pkg;

  // Table and agent sizes.
  localparam int NUM_STATES  = 64;
  localparam int NUM_ACTIONS = 8;
  localparam int NUM_AGENTS  = 16;

  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int ACTION_W    = $clog2(NUM_ACTIONS);
  localparam int AGENT_W     = $clog2(NUM_AGENTS);
  localparam int ADDR_W      = ACTION_W + STATE_W;
  localparam int TABLE_DEPTH = NUM_ACTIONS * NUM_STATES;

  // Fixed-point formats: values are Q16.16, rates are Q0.16.
  localparam int VALUE_W  = 32;
  localparam int RATE_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int DELTA_W  = VALUE_W + 2;
  localparam int MUL_B_W  = RATE_W + 1;
  localparam int PROD_W   = DELTA_W + MUL_B_W;
  localparam int SCALED_W = PROD_W - FRAC_W;
  localparam int SUM_W    = SCALED_W + 1;

  // Argmax starting value, -300.0 in Q16.16.
  localparam logic signed [VALUE_W-1:0] BEST_START = -32'sd19660800;

  // Saturation limits.
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // Command codes.
  localparam logic [1:0] CMD_STEP   = 2'd0;
  localparam logic [1:0] CMD_REWARD = 2'd1;
  localparam logic [1:0] CMD_QWRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [1:0] CFG_EXPLORE    = 2'd2;
  localparam logic [1:0] CFG_TRAIN      = 2'd3;

  // Configuration reset values.
  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST   = 16'd58982;
  localparam logic [RATE_W-1:0] EXPLORE_RST    = 16'd6554;

  // Control word of the shared multiplier.
  typedef struct packed {
    logic en;        // load a new product
    logic use_rate;  // 1: delta * learning rate, 0: Q * discount
  } mul_ctrl_t;

endpackage

### src/tqla_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read word.
// ----------------------------------------------------------------------------
module tqla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tqla_mul.sv
// ----------------------------------------------------------------------------
// Shared update multiplier
// One signed multiplier used twice per training step: first Q times the
// discount, then the temporal difference times the learning rate. The
// product is registered and offered floor-shifted to Q19.16.
// ----------------------------------------------------------------------------
module tqla_mul (
  input  logic                                 clk,
  input  tqla_pkg::mul_ctrl_t                  ctrl,
  input  logic signed [tqla_pkg::VALUE_W-1:0]  q_best,
  input  logic signed [tqla_pkg::DELTA_W-1:0]  delta,
  input  logic        [tqla_pkg::RATE_W-1:0]   discount,
  input  logic        [tqla_pkg::RATE_W-1:0]   learning_rate,
  output logic signed [tqla_pkg::SCALED_W-1:0] scaled
);

  logic signed [tqla_pkg::DELTA_W-1:0] op_a;
  logic signed [tqla_pkg::MUL_B_W-1:0] op_b;
  logic signed [tqla_pkg::PROD_W-1:0]  prod;

  // Operand selection; rates are unsigned, so they get a zero sign bit.
  always_comb begin
    if (ctrl.use_rate) begin
      op_a = delta;
      op_b = $signed({1'b0, learning_rate});
    end else begin
      op_a = tqla_pkg::DELTA_W'(q_best);
      op_b = $signed({1'b0, discount});
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod <= tqla_pkg::PROD_W'(op_a * op_b);
    end
  end

  // Arithmetic shift right by the fraction width rounds toward minus infinity.
  assign scaled = prod[tqla_pkg::PROD_W-1:tqla_pkg::FRAC_W];

endmodule

### src/tabular_q_learning_agent_unit.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent
// Step with training off: done is raised after the argmax scan (one Q entry
// per cycle through the single Q RAM port) and a decide state; a new step
// word can be taken in the cycle in which done is high.
// Step with training on: the decide state is followed by the previous-entry
// read, two passes through the shared multiplier and the write back, then
// done. Table writes return no result. Reset: a pass over all 512 entries
// clears the Q table with busy high; configuration writes are taken
// throughout. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent_unit (
  input  logic                clk,
  input  logic                rst,
  // Command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic [3:0]          agent,
  input  logic [5:0]          state,
  input  logic [2:0]          table_action,
  input  logic signed [31:0]  table_value,
  input  logic [15:0]         random_draw,
  input  logic [2:0]          explore_action,
  // Configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // Result channel
  output logic                done,
  output logic [2:0]          next_action,
  output logic                explored
);

  // Sequencer codes.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_RDPREV = 4'd4;
  localparam logic [3:0] S_MULG   = 4'd5;
  localparam logic [3:0] S_DELTA  = 4'd6;
  localparam logic [3:0] S_MULA   = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;

  localparam int SCAN_W = tqla_pkg::ACTION_W + 1;

  logic [3:0] fsm;
  logic [tqla_pkg::ADDR_W-1:0] clr_addr;
  logic [SCAN_W-1:0] scan_cnt;

  // Configuration registers.
  logic [tqla_pkg::RATE_W-1:0] learning_rate;
  logic [tqla_pkg::RATE_W-1:0] discount;
  logic [tqla_pkg::RATE_W-1:0] explore_threshold;
  logic                        training_enable;

  // Latched step word.
  logic [tqla_pkg::AGENT_W-1:0]  agent_r;
  logic [tqla_pkg::STATE_W-1:0]  state_r;
  logic [tqla_pkg::RATE_W-1:0]   draw_r;
  logic [tqla_pkg::ACTION_W-1:0] xact_r;

  // Per-agent history.
  logic [tqla_pkg::ACTION_W-1:0] last_action [tqla_pkg::NUM_AGENTS];
  logic [tqla_pkg::STATE_W-1:0]  last_state  [tqla_pkg::NUM_AGENTS];

  // Argmax and update operands.
  logic signed [tqla_pkg::VALUE_W-1:0] best_val;
  logic [tqla_pkg::ACTION_W-1:0]       best_act;
  logic signed [tqla_pkg::VALUE_W-1:0] q_best;
  logic signed [tqla_pkg::VALUE_W-1:0] q_prev;
  logic signed [tqla_pkg::VALUE_W-1:0] reward;
  logic signed [tqla_pkg::DELTA_W-1:0] delta;

  // Memory ports.
  logic                          q_we;
  logic [tqla_pkg::ADDR_W-1:0]   q_waddr;
  logic [tqla_pkg::VALUE_W-1:0]  q_wdata;
  logic [tqla_pkg::ADDR_W-1:0]   q_raddr;
  logic [tqla_pkg::VALUE_W-1:0]  q_rdata;
  logic                          rw_we;
  logic [tqla_pkg::VALUE_W-1:0]  rw_rdata;

  logic                          accept;
  logic [tqla_pkg::ADDR_W-1:0]   prev_addr;
  logic [tqla_pkg::ADDR_W-1:0]   entry_addr;
  logic [tqla_pkg::ACTION_W-1:0] scan_act;
  logic                          scan_hit;
  tqla_pkg::mul_ctrl_t           mul_ctrl;
  logic signed [tqla_pkg::SCALED_W-1:0] scaled;
  logic signed [tqla_pkg::SUM_W-1:0]    q_sum;
  logic signed [tqla_pkg::VALUE_W-1:0]  q_new;
  logic                          do_explore;
  logic [tqla_pkg::ACTION_W-1:0] chosen;

  assign busy      = (fsm != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Entry addresses are {action, state}.
  assign entry_addr = {table_action[tqla_pkg::ACTION_W-1:0], state[tqla_pkg::STATE_W-1:0]};
  assign prev_addr  = {last_action[agent_r], last_state[agent_r]};

  // The scan compares the word read in the previous cycle.
  assign scan_act = tqla_pkg::ACTION_W'(scan_cnt - SCAN_W'(1));
  assign scan_hit = (scan_cnt != '0) && ($signed(q_rdata) > best_val);

  // Exploration choice.
  assign do_explore = (draw_r < explore_threshold);
  assign chosen     = do_explore ? xact_r : best_act;

  // New Q entry, saturated to the 32-bit range.
  assign q_sum = tqla_pkg::SUM_W'(q_prev) + tqla_pkg::SUM_W'(scaled);
  always_comb begin
    if (q_sum > tqla_pkg::SUM_W'(tqla_pkg::VALUE_MAX)) begin
      q_new = tqla_pkg::VALUE_MAX;
    end else if (q_sum < tqla_pkg::SUM_W'(tqla_pkg::VALUE_MIN)) begin
      q_new = tqla_pkg::VALUE_MIN;
    end else begin
      q_new = q_sum[tqla_pkg::VALUE_W-1:0];
    end
  end

  // Q RAM port selection.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = entry_addr;
    q_wdata = table_value;
    q_raddr = {best_act, state_r};
    unique case (fsm)
      S_CLEAR: begin
        q_we    = 1'b1;
        q_waddr = clr_addr;
        q_wdata = '0;
      end
      S_IDLE: begin
        q_we = accept && (command == tqla_pkg::CMD_QWRITE);
      end
      S_SCAN: begin
        q_raddr = {scan_cnt[tqla_pkg::ACTION_W-1:0], state_r};
      end
      S_RDPREV: begin
        q_raddr = prev_addr;
      end
      S_WRITE: begin
        q_we    = 1'b1;
        q_waddr = prev_addr;
        q_wdata = q_new;
      end
      default: begin
        q_raddr = {best_act, state_r};
      end
    endcase
  end

  assign rw_we = accept && (command == tqla_pkg::CMD_REWARD);

  // Shared multiplier control.
  always_comb begin
    mul_ctrl.en       = (fsm == S_MULG) || (fsm == S_MULA);
    mul_ctrl.use_rate = (fsm == S_MULA);
  end

  tqla_ram #(
    .WIDTH(tqla_pkg::VALUE_W),
    .DEPTH(tqla_pkg::TABLE_DEPTH)
  ) u_q_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  tqla_ram #(
    .WIDTH(tqla_pkg::VALUE_W),
    .DEPTH(tqla_pkg::TABLE_DEPTH)
  ) u_reward_ram (
    .clk  (clk),
    .we   (rw_we),
    .waddr(entry_addr),
    .wdata(table_value),
    .raddr(prev_addr),
    .rdata(rw_rdata)
  );

  tqla_mul u_mul (
    .clk          (clk),
    .ctrl         (mul_ctrl),
    .q_best       (q_best),
    .delta        (delta),
    .discount     (discount),
    .learning_rate(learning_rate),
    .scaled       (scaled)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate     <= tqla_pkg::LEARN_RATE_RST;
      discount          <= tqla_pkg::DISCOUNT_RST;
      explore_threshold <= tqla_pkg::EXPLORE_RST;
      training_enable   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tqla_pkg::CFG_LEARN_RATE: learning_rate     <= cfg_data;
        tqla_pkg::CFG_DISCOUNT:   discount          <= cfg_data;
        tqla_pkg::CFG_EXPLORE:    explore_threshold <= cfg_data;
        tqla_pkg::CFG_TRAIN:      training_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Step word capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      agent_r <= agent[tqla_pkg::AGENT_W-1:0];
      state_r <= state[tqla_pkg::STATE_W-1:0];
      draw_r  <= random_draw;
      xact_r  <= explore_action[tqla_pkg::ACTION_W-1:0];
    end
  end

  // Update datapath registers.
  always_ff @(posedge clk) begin
    if (fsm == S_RDPREV) begin
      q_best <= $signed(q_rdata);
      reward <= $signed(rw_rdata);
    end
    if (fsm == S_MULG) begin
      q_prev <= $signed(q_rdata);
    end
    if (fsm == S_DELTA) begin
      delta <= tqla_pkg::DELTA_W'(reward) + tqla_pkg::DELTA_W'(scaled)
             - tqla_pkg::DELTA_W'(q_prev);
    end
  end

  // Per-agent history, recorded at the end of a training step.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tqla_pkg::NUM_AGENTS; i++) begin
        last_action[i] <= '0;
        last_state[i]  <= '0;
      end
    end else if (fsm == S_WRITE) begin
      last_action[agent_r] <= chosen;
      last_state[agent_r]  <= state_r;
    end
  end

  // Sequencer, argmax scan and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm      <= S_CLEAR;
      clr_addr <= '0;
      scan_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (fsm)
        S_CLEAR: begin
          clr_addr <= clr_addr + tqla_pkg::ADDR_W'(1);
          if (clr_addr == tqla_pkg::ADDR_W'(tqla_pkg::TABLE_DEPTH - 1)) begin
            fsm <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (command == tqla_pkg::CMD_STEP)) begin
            fsm      <= S_SCAN;
            scan_cnt <= '0;
            best_val <= tqla_pkg::BEST_START;
            best_act <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_hit) begin
            best_val <= $signed(q_rdata);
            best_act <= scan_act;
          end
          if (scan_cnt == SCAN_W'(tqla_pkg::NUM_ACTIONS)) begin
            fsm <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (training_enable) begin
            fsm <= S_RDPREV;
          end else begin
            fsm         <= S_IDLE;
            done        <= 1'b1;
            next_action <= 3'(best_act);
            explored    <= 1'b0;
          end
        end
        S_RDPREV: fsm <= S_MULG;
        S_MULG:   fsm <= S_DELTA;
        S_DELTA:  fsm <= S_MULA;
        S_MULA:   fsm <= S_WRITE;
        S_WRITE: begin
          fsm         <= S_IDLE;
          done        <= 1'b1;
          next_action <= 3'(chosen);
          explored    <= do_explore;
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule
